// ===== hdl/dhf_pkg.sv =====
// Shared types and constants for the 3x3 depth hole filler.
// Used by the channel interfaces, the line store, the window and the top level.
`timescale 1ns / 1ps
`default_nettype none

package dhf_pkg;

  // Field widths fixed by the stream format
  localparam int DEPTH_W    = 16;  // depth word on both channels
  localparam int GEOM_W     = 11;  // frame_width / frame_height registers
  localparam int ROW_W      = 10;  // output row counter
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  // Geometry limits and register reset values
  localparam int MAX_HEIGHT   = 1024;
  localparam int RESET_WIDTH  = 640;
  localparam int RESET_HEIGHT = 480;

  // Defaults for the top-level parameters
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int DEPTH_BITS_DEF = 16;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FILL_ENABLE  = 2'd0,
    REG_FRAME_WIDTH  = 2'd1,
    REG_FRAME_HEIGHT = 2'd2
  } reg_idx_t;

  // Border and end-of-frame flags of one output pixel
  typedef struct packed {
    logic left;
    logic right;
    logic top;
    logic bottom;
    logic eof;
  } pos_flags_t;

endpackage

`default_nettype wire

// ===== hdl/dhf_if.sv =====
// Valid/ready channel interfaces: pixel input, filtered output, register writes.
// Payload widths come from dhf_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface dhf_in_if;
  logic                       valid;
  logic                       ready;
  logic [dhf_pkg::DEPTH_W-1:0] depth_mm;
  logic                       flush;

  modport source (output valid, output depth_mm, output flush, input ready);
  modport sink   (input valid, input depth_mm, input flush, output ready);
endinterface

interface dhf_out_if;
  logic                       valid;
  logic                       ready;
  logic [dhf_pkg::DEPTH_W-1:0] filled_mm;
  logic                       end_of_frame;

  modport source (output valid, output filled_mm, output end_of_frame, input ready);
  modport sink   (input valid, input filled_mm, input end_of_frame, output ready);
endinterface

interface dhf_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [dhf_pkg::CFG_IDX_W-1:0]  index;
  logic [dhf_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/dhf_line_store.sv =====
// Two-row line buffer (upper and middle row per column) in one synchronous RAM.
// Registered read; a write to the address being read is forwarded.
`timescale 1ns / 1ps
`default_nettype none

module dhf_line_store #(
  parameter int DEPTH      = dhf_pkg::MAX_WIDTH_DEF,
  parameter int DEPTH_BITS = dhf_pkg::DEPTH_BITS_DEF,
  localparam int AW        = $clog2(DEPTH)
) (
  input  wire logic                  clk,
  input  wire logic                  rd_en,
  input  wire logic [AW-1:0]         rd_addr,
  output logic      [DEPTH_BITS-1:0] rd_upper,
  output logic      [DEPTH_BITS-1:0] rd_middle,
  input  wire logic                  wr_en,
  input  wire logic [AW-1:0]         wr_addr,
  input  wire logic [DEPTH_BITS-1:0] wr_upper,
  input  wire logic [DEPTH_BITS-1:0] wr_middle
);

  logic [2*DEPTH_BITS-1:0] mem [DEPTH];
  logic [2*DEPTH_BITS-1:0] mem_q;
  logic [2*DEPTH_BITS-1:0] fwd_word;
  logic                    fwd_hit;

  // Read-first RAM; a column is written back after its own read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_upper, wr_middle};
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  // Same column written while read (narrow frames): take the new word
  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_hit  <= wr_en && (wr_addr == rd_addr);
      fwd_word <= {wr_upper, wr_middle};
    end
  end

  assign rd_upper  = fwd_hit ? fwd_word[2*DEPTH_BITS-1:DEPTH_BITS] : mem_q[2*DEPTH_BITS-1:DEPTH_BITS];
  assign rd_middle = fwd_hit ? fwd_word[DEPTH_BITS-1:0]            : mem_q[DEPTH_BITS-1:0];

endmodule

`default_nettype wire

// ===== hdl/dhf_window.sv =====
// 3x3 sliding window and the hole-fill decision (minimum of nonzero neighbors).
// Uses dhf_pkg::pos_flags_t for the border clipping.
`timescale 1ns / 1ps
`default_nettype none

module dhf_window #(
  parameter int DEPTH_BITS = dhf_pkg::DEPTH_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  shift_en,
  input  wire logic [DEPTH_BITS-1:0] col_upper,
  input  wire logic [DEPTH_BITS-1:0] col_middle,
  input  wire logic [DEPTH_BITS-1:0] col_bottom,
  input  wire dhf_pkg::pos_flags_t   flags,
  input  wire logic                  fill_enable,
  output logic      [DEPTH_BITS-1:0] fill_value
);

  // win[col*3 + row]; column 2 is the newest, row 2 the incoming row
  logic [DEPTH_BITS-1:0] win [9];
  logic [DEPTH_BITS-1:0] key [9];
  logic [8:0]            cand;
  logic [DEPTH_BITS-1:0] lvl1 [4];
  logic [DEPTH_BITS-1:0] lvl2 [2];
  logic [DEPTH_BITS-1:0] lvl3;
  logic [DEPTH_BITS-1:0] best;
  logic                  multi;
  logic [DEPTH_BITS-1:0] center;

  function automatic logic [DEPTH_BITS-1:0] min2(input logic [DEPTH_BITS-1:0] a,
                                                 input logic [DEPTH_BITS-1:0] b);
    return (b < a) ? b : a;
  endfunction

  // Shift left by one column, new column enters on the right
  always_ff @(posedge clk) begin
    if (shift_en) begin
      for (int k = 0; k < 3; k++) begin
        win[k]     <= win[3 + k];
        win[3 + k] <= win[6 + k];
      end
      win[6] <= col_upper;
      win[7] <= col_middle;
      win[8] <= col_bottom;
    end
  end

  // Candidates: inside the frame and nonzero; others sort last
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        cand[c*3 + r] = !((c == 0 && flags.left) || (c == 2 && flags.right) ||
                          (r == 0 && flags.top)  || (r == 2 && flags.bottom)) &&
                        (win[c*3 + r] != '0);
        key[c*3 + r]  = cand[c*3 + r] ? win[c*3 + r] : '1;
      end
    end
  end

  // Minimum tree, four levels
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      lvl1[i] = min2(key[2*i], key[2*i + 1]);
    end
    lvl2[0] = min2(lvl1[0], lvl1[1]);
    lvl2[1] = min2(lvl1[2], lvl1[3]);
    lvl3    = min2(lvl2[0], lvl2[1]);
    best    = min2(lvl3, key[8]);
  end

  // At least two candidates: clear lowest set bit, anything left
  assign multi  = |(cand & (cand - 9'd1));
  assign center = win[4];

  assign fill_value = (!fill_enable || center != '0) ? center :
                      (multi ? best : '0);

endmodule

`default_nettype wire

// ===== hdl/depth_hole_fill_min_3x3.sv =====
// Top level of the 3x3 depth hole filler: registers, position counters, pipeline control.
// Depends on dhf_pkg, dhf_if, dhf_line_store and dhf_window.
`timescale 1ns / 1ps
`default_nettype none

// Streaming hole filler for raster-order depth frames in millimetres. Each pixel word
// yields one output word; a zero pixel becomes the minimum of the nonzero pixels of its
// 3x3 window (clipped at the frame edges) when at least two are present, else stays 0.
// One word per clock is accepted sustained while the output is not held: the line buffer
// is a single RAM read when a word enters and written back as that word leaves the first
// stage, with forwarding for narrow frames. An output is due frame_width + 1 accepted
// words after its pixel and passes stage 1, stage 2 and the output register after that
// later word is accepted, so send frame_width + 1 flush words after each frame;
// end_of_frame marks the last pixel. Flush words inside a frame are dropped, pixel words
// after the last pixel act as flush. Writing width or height restarts the frame position.
// Register writes are always ready and must be made while the block is idle.
module depth_hole_fill_min_3x3 #(
  parameter int MAX_WIDTH  = dhf_pkg::MAX_WIDTH_DEF,
  parameter int DEPTH_BITS = dhf_pkg::DEPTH_BITS_DEF
) (
  input wire logic  clk,
  input wire logic  rst,
  dhf_in_if.sink    pixel,
  dhf_out_if.source result,
  dhf_cfg_if.sink   cfg
);

  localparam int CW  = $clog2(MAX_WIDTH);      // column address
  localparam int WCW = $clog2(MAX_WIDTH + 1);  // column count up to MAX_WIDTH
  localparam int GW  = dhf_pkg::GEOM_W;
  localparam int RW  = dhf_pkg::ROW_W;

  // Configuration registers
  logic          fill_enable;
  logic [GW-1:0] frame_width;
  logic [GW-1:0] frame_height;
  logic [WCW-1:0] w_used;
  logic [GW-1:0]  h_used;
  logic           cfg_take;
  logic           geom_write;

  // Position counters
  logic [WCW-1:0] in_column, in_column_next;
  logic [GW-1:0]  in_row, in_row_next;
  logic [WCW-1:0] out_column, out_column_next;
  logic [RW-1:0]  out_row, out_row_next;

  // Entry decode
  logic                  in_take;
  logic                  in_frame;
  logic                  live;
  logic                  emit0;
  logic [DEPTH_BITS-1:0] v0;
  logic [WCW-1:0]        col_inc;
  logic [WCW-1:0]        out_col_inc;
  dhf_pkg::pos_flags_t   flags0;

  // Stage 1: line store read returns
  logic                  s1_valid;
  logic [DEPTH_BITS-1:0] s1_v;
  logic [CW-1:0]         s1_col;
  logic                  s1_emit;
  dhf_pkg::pos_flags_t   s1_flags;
  logic                  s1_go;
  logic                  s1_ready;
  logic [DEPTH_BITS-1:0] rd_upper;
  logic [DEPTH_BITS-1:0] rd_middle;

  // Stage 2: window holds this word's neighborhood
  logic                  s2_valid;
  logic                  s2_emit;
  dhf_pkg::pos_flags_t   s2_flags;
  logic                  s2_go;
  logic                  s2_ready;
  logic [DEPTH_BITS-1:0] fill_value;

  // Output register
  logic                        out_valid;
  logic [dhf_pkg::DEPTH_W-1:0] out_mm;
  logic                        out_eof;
  logic                        out_free;

  // Geometry clamped to the supported range
  always_comb begin
    if (frame_width == '0) begin
      w_used = WCW'(1);
    end else if (32'(frame_width) > MAX_WIDTH) begin
      w_used = WCW'(MAX_WIDTH);
    end else begin
      w_used = WCW'(frame_width);
    end
    if (frame_height == '0) begin
      h_used = GW'(1);
    end else if (32'(frame_height) > dhf_pkg::MAX_HEIGHT) begin
      h_used = GW'(dhf_pkg::MAX_HEIGHT);
    end else begin
      h_used = frame_height;
    end
  end

  // Register writes
  assign cfg.ready  = 1'b1;
  assign cfg_take   = cfg.valid && cfg.ready;
  assign geom_write = cfg_take &&
                      (dhf_pkg::reg_idx_t'(cfg.index) == dhf_pkg::REG_FRAME_WIDTH ||
                       dhf_pkg::reg_idx_t'(cfg.index) == dhf_pkg::REG_FRAME_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_enable  <= 1'b1;
      frame_width  <= GW'(dhf_pkg::RESET_WIDTH);
      frame_height <= GW'(dhf_pkg::RESET_HEIGHT);
    end else if (cfg_take) begin
      unique case (dhf_pkg::reg_idx_t'(cfg.index))
        dhf_pkg::REG_FILL_ENABLE:  fill_enable  <= cfg.data[0];
        dhf_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg.data;
        dhf_pkg::REG_FRAME_HEIGHT: frame_height <= cfg.data;
        default: ;
      endcase
    end
  end

  // Handshake chain from the output back to the input
  assign out_free = !out_valid || result.ready;
  assign s2_go    = s2_valid && (out_free || !s2_emit);
  assign s2_ready = !s2_valid || s2_go;
  assign s1_go    = s1_valid && s2_ready;
  assign s1_ready = !s1_valid || s1_go;
  assign pixel.ready = s1_ready;

  // Entry: decide what the word does from the position counters
  assign in_take  = pixel.valid && pixel.ready;
  assign in_frame = in_row < h_used;
  assign live     = in_take && !(pixel.flush && in_frame);
  assign v0       = in_frame ? pixel.depth_mm[DEPTH_BITS-1:0] : '0;
  assign emit0    = (in_row >= GW'(2)) || (in_row == GW'(1) && in_column != '0);
  assign col_inc     = in_column + WCW'(1);
  assign out_col_inc = out_column + WCW'(1);

  always_comb begin
    flags0.left   = (out_column == '0);
    flags0.right  = (out_col_inc >= w_used);
    flags0.top    = (out_row == '0);
    flags0.bottom = ({1'b0, out_row} + GW'(1)) >= h_used;
    flags0.eof    = flags0.right && flags0.bottom;
  end

  // Counter update: a geometry write or the last output pixel restarts the whole frame
  always_comb begin
    in_column_next  = in_column;
    in_row_next     = in_row;
    out_column_next = out_column;
    out_row_next    = out_row;
    if (geom_write) begin
      in_column_next  = '0;
      in_row_next     = '0;
      out_column_next = '0;
      out_row_next    = '0;
    end else if (live) begin
      if (emit0 && flags0.eof) begin
        in_column_next  = '0;
        in_row_next     = '0;
        out_column_next = '0;
        out_row_next    = '0;
      end else begin
        if (col_inc >= w_used) begin
          in_column_next = '0;
          in_row_next    = in_row + GW'(1);
        end else begin
          in_column_next = col_inc;
        end
        if (emit0) begin
          if (flags0.right) begin
            out_column_next = '0;
            out_row_next    = out_row + RW'(1);
          end else begin
            out_column_next = out_col_inc;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_column  <= '0;
      in_row     <= '0;
      out_column <= '0;
      out_row    <= '0;
    end else begin
      in_column  <= in_column_next;
      in_row     <= in_row_next;
      out_column <= out_column_next;
      out_row    <= out_row_next;
    end
  end

  // Stage 1 registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (live) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (live) begin
      s1_v     <= v0;
      s1_col   <= in_column[CW-1:0];
      s1_emit  <= emit0;
      s1_flags <= flags0;
    end
  end

  // Line store: read on entry, shift rows and write back in stage 1
  dhf_line_store #(
    .DEPTH      (MAX_WIDTH),
    .DEPTH_BITS (DEPTH_BITS)
  ) u_line_store (
    .clk       (clk),
    .rd_en     (live),
    .rd_addr   (in_column[CW-1:0]),
    .rd_upper  (rd_upper),
    .rd_middle (rd_middle),
    .wr_en     (s1_go),
    .wr_addr   (s1_col),
    .wr_upper  (rd_middle),
    .wr_middle (s1_v)
  );

  // Stage 2 registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_go) begin
      s2_valid <= 1'b1;
    end else if (s2_go) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      s2_emit  <= s1_emit;
      s2_flags <= s1_flags;
    end
  end

  dhf_window #(
    .DEPTH_BITS (DEPTH_BITS)
  ) u_window (
    .clk         (clk),
    .shift_en    (s1_go),
    .col_upper   (rd_upper),
    .col_middle  (rd_middle),
    .col_bottom  (s1_v),
    .flags       (s2_flags),
    .fill_enable (fill_enable),
    .fill_value  (fill_value)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_go && s2_emit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go && s2_emit) begin
      out_mm  <= dhf_pkg::DEPTH_W'(fill_value);
      out_eof <= s2_flags.eof;
    end
  end

  assign result.valid        = out_valid;
  assign result.filled_mm    = out_mm;
  assign result.end_of_frame = out_eof;

`ifndef SYNTHESIS
  // Last output pixel of a frame puts every position counter back to zero
  a_eof_restart: assert property (@(posedge clk) disable iff (rst)
    live && emit0 && flags0.eof |=>
      in_column == '0 && in_row == '0 && out_column == '0 && out_row == '0)
    else $error("frame end did not restart position counters");

  // Input row counter never exceeds h_used + 1 before the restart
  a_row_bound: assert property (@(posedge clk) disable iff (rst)
    {1'b0, in_row} <= ({1'b0, h_used} + (GW + 1)'(1)))
    else $error("input row counter ran past the drain");

  // A stalled stage 2 keeps its word and the window does not move
  a_s2_hold: assert property (@(posedge clk) disable iff (rst)
    s2_valid && !s2_go |=> s2_valid && $stable(s2_flags) && !$past(s1_go))
    else $error("stage 2 word lost while stalled");

  // No word is pushed into a full output register
  a_out_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !result.ready |-> !(s2_go && s2_emit))
    else $error("output register overwritten");
`endif

endmodule

`default_nettype wire
